@@ hw/rtl/ggc_pkg.sv @@
// ----------------------------------------------------------------------------
// ggc_pkg
// Shared widths, operation codes, controller states and the command and
// status structs that join the coloring controller and its datapath.
// ----------------------------------------------------------------------------
package ggc_pkg;

  // graph size and field widths
  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned VERT_W       = 6;
  localparam int unsigned COLOR_W      = 6;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned VCNT_W       = 7;

  // first-fit search walks the used-color set in chunks of eight
  localparam int unsigned CHUNK_W      = 8;
  localparam int unsigned CHUNK_SEL_W  = 3;
  localparam int unsigned CHUNK_IDX_W  = VERT_W - CHUNK_SEL_W;

  localparam logic [VCNT_W-1:0]      VCNT_RESET = VCNT_W'(64);
  localparam logic [VCNT_W-1:0]      VCNT_MAX   = VCNT_W'(MAX_VERTICES);
  localparam logic [CHUNK_IDX_W-1:0] CHUNK_LAST = CHUNK_IDX_W'(MAX_VERTICES / CHUNK_W - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_COLOR    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  typedef logic [MAX_VERTICES-1:0] row_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_ROW,
    ST_SCAN,
    ST_FIND,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic adj_rd_a;
    logic adj_rd_b;
    logic adj_wr_a;
    logic adj_wr_b;
    logic clr_colored;
    logic row_load;
    logic scan_step;
    logic find_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_edge;
    logic is_color;
    logic is_clear;
    logic scan_done;
    logic find_hit;
    logic out_free;
  } stat_t;

endpackage

@@ hw/rtl/ggc_ifs.sv @@
// ----------------------------------------------------------------------------
// ggc channel interfaces
// Valid/ready channels for the operation items and the coloring results.
// ----------------------------------------------------------------------------
interface ggc_in_if import ggc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [VERT_W-1:0] vertex_a;
  logic [VERT_W-1:0] vertex_b;

  modport source (output valid, op, vertex_a, vertex_b, input ready);
  modport sink   (input valid, op, vertex_a, vertex_b, output ready);
endinterface

interface ggc_out_if import ggc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VERT_W-1:0]  vertex;
  logic [COLOR_W-1:0] color;

  modport source (output valid, vertex, color, input ready);
  modport sink   (input valid, vertex, color, output ready);
endinterface

@@ hw/rtl/ggc_ram.sv @@
// ----------------------------------------------------------------------------
// ggc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ggc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/ggc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ggc_ctrl
// Sequencer for one operation at a time: edge insert as two row
// read-modify-writes, coloring as row fetch, neighbor scan, first-fit search.
// ----------------------------------------------------------------------------
module ggc_ctrl import ggc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (st.is_edge) begin
          cmd.adj_rd_a = 1'b1;
          state_nxt    = ST_EDGE_A;
        end else if (st.is_color) begin
          cmd.adj_rd_a = 1'b1;
          state_nxt    = ST_ROW;
        end else if (st.is_clear) begin
          cmd.clr_colored = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EDGE_A: begin
        cmd.adj_wr_a = 1'b1;
        cmd.adj_rd_b = 1'b1;
        state_nxt    = ST_EDGE_B;
      end
      ST_EDGE_B: begin
        cmd.adj_wr_b = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_ROW: begin
        cmd.row_load = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find_step = 1'b1;
        if (st.find_hit) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/ggc_dp.sv @@
// ----------------------------------------------------------------------------
// ggc_dp
// Datapath: adjacency and color memories, colored marks, neighbor scan,
// used-color set, first-fit chunk search and the result register.
// ----------------------------------------------------------------------------
module ggc_dp import ggc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [OP_W-1:0]    in_op,
  input  logic [VERT_W-1:0]  in_vertex_a,
  input  logic [VERT_W-1:0]  in_vertex_b,
  input  logic               cfg_wr_en,
  input  logic [VCNT_W-1:0]  cfg_wr_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VERT_W-1:0]  out_vertex,
  output logic [COLOR_W-1:0] out_color
);

  logic [OP_W-1:0]        op_r;
  logic [VERT_W-1:0]      a_r;
  logic [VERT_W-1:0]      b_r;
  logic [VCNT_W-1:0]      vcount_r;
  logic [VCNT_W-1:0]      n_w;
  logic                   a_ok;
  logic                   b_ok;

  logic                   adj_re;
  logic                   adj_we;
  logic [VERT_W-1:0]      adj_raddr;
  logic [VERT_W-1:0]      adj_waddr;
  row_t                   adj_wdata;
  row_t                   adj_rdata;
  row_t                   row_vld_r;
  logic                   rd_vld_r;
  row_t                   row_eff;

  row_t                   row_r;
  row_t                   colored_mask_r;
  row_t                   used_r;
  logic [VCNT_W-1:0]      u_r;
  logic                   u_lt_n;
  logic                   scan_issue;
  logic                   pend_r;
  logic [COLOR_W-1:0]     col_rdata;

  logic [CHUNK_IDX_W-1:0] k_r;
  logic [CHUNK_W-1:0]     free_w;
  logic [CHUNK_SEL_W-1:0] ffs_w;
  logic                   find_any;
  logic                   find_hit;
  logic [COLOR_W-1:0]     color_r;

  logic                   out_valid_r;
  logic [VERT_W-1:0]      out_vertex_r;
  logic [COLOR_W-1:0]     out_color_r;

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      a_r  <= in_vertex_a;
      b_r  <= in_vertex_b;
    end
  end

  // vertex count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCNT_RESET;
    end else if (cfg_wr_en) begin
      vcount_r <= cfg_wr_data;
    end
  end

  // active vertex count and range checks
  assign n_w  = (vcount_r > VCNT_MAX) ? VCNT_MAX : vcount_r;
  assign a_ok = {1'b0, a_r} < n_w;
  assign b_ok = {1'b0, b_r} < n_w;

  // adjacency memory ports
  assign adj_re    = cmd.adj_rd_a | cmd.adj_rd_b;
  assign adj_raddr = cmd.adj_rd_b ? b_r : a_r;
  assign adj_we    = cmd.adj_wr_a | cmd.adj_wr_b;
  assign adj_waddr = cmd.adj_wr_b ? b_r : a_r;
  assign row_eff   = rd_vld_r ? adj_rdata : '0;
  assign adj_wdata = row_eff | (row_t'(1) << (cmd.adj_wr_b ? a_r : b_r));

  ggc_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // row valid bits, an unwritten row reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (adj_we) begin
        row_vld_r[adj_waddr] <= 1'b1;
      end
      if (adj_re) begin
        rd_vld_r <= row_vld_r[adj_raddr];
      end
    end
  end

  // neighbor row of the vertex being colored
  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      row_r <= row_eff;
    end
  end

  // neighbor scan, one vertex per cycle
  assign u_lt_n     = u_r < n_w;
  assign scan_issue = cmd.scan_step && u_lt_n && row_r[u_r[VERT_W-1:0]]
                      && colored_mask_r[u_r[VERT_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r    <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= scan_issue;
      if (cmd.row_load) begin
        u_r <= '0;
      end else if (cmd.scan_step && u_lt_n) begin
        u_r <= u_r + VCNT_W'(1);
      end
    end
  end

  ggc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_VERTICES)
  ) u_color_ram (
    .clk   (clk),
    .we    (cmd.out_load),
    .waddr (a_r),
    .wdata (color_r),
    .re    (scan_issue),
    .raddr (u_r[VERT_W-1:0]),
    .rdata (col_rdata)
  );

  // used-color set
  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      used_r <= '0;
    end else if (pend_r) begin
      used_r[col_rdata] <= 1'b1;
    end
  end

  // free colors in the current chunk, colors at or above n count as free
  always_comb begin
    free_w = '0;
    ffs_w  = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      free_w[j] = !used_r[{k_r, CHUNK_SEL_W'(j)}]
                  || ({1'b0, k_r, CHUNK_SEL_W'(j)} >= n_w);
    end
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (free_w[j]) begin
        ffs_w = CHUNK_SEL_W'(j);
      end
    end
  end

  assign find_any = |free_w;
  assign find_hit = find_any || (k_r == CHUNK_LAST);

  // first-fit chunk walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.row_load) begin
      k_r <= '0;
    end else if (cmd.find_step && !find_hit) begin
      k_r <= k_r + CHUNK_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find_step && find_hit) begin
      color_r <= find_any ? {k_r, ffs_w} : '0;
    end
  end

  // colored marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colored_mask_r <= '0;
    end else if (cmd.clr_colored) begin
      colored_mask_r <= '0;
    end else if (cmd.out_load) begin
      colored_mask_r[a_r] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_vertex_r <= a_r;
      out_color_r  <= color_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_vertex = out_vertex_r;
  assign out_color  = out_color_r;

  // status to the controller
  assign st.is_edge   = (op_r == OP_ADD_EDGE) && a_ok && b_ok && (a_r != b_r);
  assign st.is_color  = (op_r == OP_COLOR) && a_ok;
  assign st.is_clear  = (op_r == OP_CLEAR);
  assign st.scan_done = !u_lt_n && !pend_r;
  assign st.find_hit  = find_hit;
  assign st.out_free  = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  // second half of an edge insert always follows the first
  a_edge_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cmd.adj_wr_a) |=> cmd.adj_wr_b)
    else $error("edge insert did not update the second row");

  // the reported color is never one a colored neighbor holds
  a_color_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !used_r[color_r])
    else $error("assigned color clashes with a neighbor");

  // a colored vertex is marked right after its result is loaded
  a_mark_set: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cmd.out_load) |=> colored_mask_r[$past(a_r)])
    else $error("colored mark missing after coloring");
`endif

endmodule

@@ hw/rtl/greedy_graph_coloring.sv @@
// One item in work at a time. Coloring a vertex fetches its adjacency row,
// scans n = min(vertex count, 64) neighbors at one neighbor per cycle, runs
// the first-fit search chunk by chunk and waits until out_ch can take the result.
// Edge insert does two adjacency row read-modify-writes; clear and ignored
// items end after decode. Synchronous active-low reset clears control, the
// colored marks and the row valid bits and sets the vertex count to 64.
// ----------------------------------------------------------------------------
// greedy_graph_coloring
// First-fit greedy graph coloring over an adjacency bit matrix, with edge
// insert, color vertex and clear colors operations.
// ----------------------------------------------------------------------------
module greedy_graph_coloring import ggc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [VCNT_W-1:0] cfg_wr_data,
  ggc_in_if.sink            in_ch,
  ggc_out_if.source         out_ch
);

  cmd_t  cmd;
  stat_t st;

  // controller
  ggc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  ggc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_op       (in_ch.op),
    .in_vertex_a (in_ch.vertex_a),
    .in_vertex_b (in_ch.vertex_b),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_vertex  (out_ch.vertex),
    .out_color   (out_ch.color)
  );

endmodule
